[sv/csvop_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
package csvop_pkg;

  typedef enum logic [3:0] {
    PH_TYPE      = 4'd0,
    PH_COMMA1    = 4'd1,
    PH_LOCATE    = 4'd2,
    PH_TRACK     = 4'd3,
    PH_STAMP     = 4'd4,
    PH_REF       = 4'd5,
    PH_NEWREF    = 4'd6,
    PH_SIDE      = 4'd7,
    PH_SIDECOMMA = 4'd8,
    PH_SHARES    = 4'd9,
    PH_PRICE     = 4'd10,
    PH_SYMBOL    = 4'd11,
    PH_ATTR      = 4'd12,
    PH_TRAIL     = 4'd13
  } phase_e;

  localparam logic [7:0] ChA     = 8'h41;
  localparam logic [7:0] ChS     = 8'h53;
  localparam logic [7:0] ChF     = 8'h46;
  localparam logic [7:0] ChX     = 8'h58;
  localparam logic [7:0] ChD     = 8'h44;
  localparam logic [7:0] ChU     = 8'h55;
  localparam logic [7:0] ChB     = 8'h42;
  localparam logic [7:0] ChO     = 8'h4F;
  localparam logic [7:0] ChQ     = 8'h51;
  localparam logic [7:0] ChM     = 8'h4D;
  localparam logic [7:0] ChE     = 8'h45;
  localparam logic [7:0] ChC     = 8'h43;
  localparam logic [7:0] ChComma = 8'h2C;
  localparam logic [7:0] Ch0     = 8'h30;
  localparam logic [7:0] Ch9     = 8'h39;

  typedef struct packed {
    logic [7:0] char_in;
    logic       is_last;
    logic       empty_line;
  } in_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  msg_type;
    logic [15:0] stock_locate;
    logic [15:0] track_number;
    logic [47:0] time_stamp;
    logic [63:0] order_ref;
    logic [63:0] new_order_ref;
    logic [7:0]  side_or_event;
    logic [31:0] share_count;
    logic [31:0] price_value;
    logic [63:0] symbol_chars;
    logic [31:0] attribution_chars;
  } out_t;

endpackage
`default_nettype wire

[sv/csv_order_message_parser_top.sv]
// Order-message line parser. One character is taken per transfer and one
// result is produced per line, on the transfer marked is_last. An item is
// taken every cycle unless a waiting result is held by out_stall_i; the
// result appears in the cycle after the last character, in an output register,
// while the next line can already stream in. The cycle is set by the
// per-character step: a 64-bit multiply-by-ten add and an overflow compare.
// Rejected lines give ok=0 with every field zero.
`timescale 1ns / 1ps
`default_nettype none
module csv_order_message_parser_top (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_stall_o,
  input  wire csvop_pkg::in_t   in_data_i,
  output logic                  out_valid_o,
  input  wire logic             out_stall_i,
  output csvop_pkg::out_t       out_data_o
);

  csvop_pkg::phase_e ph_q, ph_d;
  logic [63:0] acc_q, acc_d;
  logic        err_q, err_d;
  logic [3:0]  pos_q, pos_d;
  logic [7:0]  typ_q, typ_d, side_q, side_d;
  logic [15:0] loc_q, loc_d, trk_q, trk_d;
  logic [47:0] stp_q, stp_d;
  logic [63:0] ref_q, ref_d, nref_q, nref_d, sym_q, sym_d;
  logic [31:0] shr_q, shr_d, prc_q, prc_d, attr_q, attr_d;
  logic        ovalid_q;
  csvop_pkg::out_t odata_q, res;

  logic        take;
  logic [7:0]  c;
  logic        is_comma, is_digit, t_af, t_sdx, side_ok;
  logic [3:0]  dig;
  logic [67:0] prod;
  logic [63:0] mx;
  logic        acc_ok;

  assign in_stall_o  = ovalid_q & out_stall_i;
  assign take        = in_valid_i & ~in_stall_o;
  assign out_valid_o = ovalid_q;
  assign out_data_o  = odata_q;

  assign c        = in_data_i.char_in;
  assign is_comma = (c == csvop_pkg::ChComma);
  assign is_digit = (c >= csvop_pkg::Ch0) && (c <= csvop_pkg::Ch9);
  assign dig      = 4'(c - csvop_pkg::Ch0);
  assign prod     = {4'd0, acc_q} * 68'd10 + {64'd0, dig};
  assign t_af     = (typ_q == csvop_pkg::ChA) || (typ_q == csvop_pkg::ChF);
  assign t_sdx    = (typ_q == csvop_pkg::ChS) || (typ_q == csvop_pkg::ChD) ||
                    (typ_q == csvop_pkg::ChX);

  always_comb begin
    case (ph_q)
      csvop_pkg::PH_LOCATE, csvop_pkg::PH_TRACK: mx = 64'hFFFF;
      csvop_pkg::PH_STAMP: mx = 64'hFFFF_FFFF_FFFF;
      csvop_pkg::PH_SHARES, csvop_pkg::PH_PRICE: mx = 64'hFFFF_FFFF;
      default: mx = '1;
    endcase
  end
  assign acc_ok = (prod[67:64] == 4'd0) && (prod[63:0] <= mx);

  always_comb begin
    if (t_af) side_ok = (c == csvop_pkg::ChB) || (c == csvop_pkg::ChS);
    else if (typ_q == csvop_pkg::ChS)
      side_ok = (c == csvop_pkg::ChO) || (c == csvop_pkg::ChS) ||
                (c == csvop_pkg::ChQ) || (c == csvop_pkg::ChM) ||
                (c == csvop_pkg::ChE) || (c == csvop_pkg::ChC);
    else side_ok = 1'b0;
  end

  always_comb begin
    ph_d = ph_q; acc_d = acc_q; err_d = err_q; pos_d = pos_q;
    typ_d = typ_q; side_d = side_q; loc_d = loc_q; trk_d = trk_q;
    stp_d = stp_q; ref_d = ref_q; nref_d = nref_q; sym_d = sym_q;
    shr_d = shr_q; prc_d = prc_q; attr_d = attr_q;
    if (!in_data_i.empty_line && !err_q) begin
      case (ph_q)
        csvop_pkg::PH_TYPE: begin
          if ((c == csvop_pkg::ChA) || (c == csvop_pkg::ChS) ||
              (c == csvop_pkg::ChF) || (c == csvop_pkg::ChX) ||
              (c == csvop_pkg::ChD) || (c == csvop_pkg::ChU)) begin
            typ_d = c; ph_d = csvop_pkg::PH_COMMA1;
          end else err_d = 1'b1;
        end
        csvop_pkg::PH_COMMA1: begin
          if (is_comma) ph_d = csvop_pkg::PH_LOCATE; else err_d = 1'b1;
        end
        csvop_pkg::PH_LOCATE, csvop_pkg::PH_TRACK, csvop_pkg::PH_STAMP,
        csvop_pkg::PH_REF, csvop_pkg::PH_NEWREF, csvop_pkg::PH_SHARES,
        csvop_pkg::PH_PRICE: begin
          if (is_comma) begin
            case (ph_q)
              csvop_pkg::PH_LOCATE: loc_d = acc_q[15:0];
              csvop_pkg::PH_TRACK:  trk_d = acc_q[15:0];
              csvop_pkg::PH_STAMP:  stp_d = acc_q[47:0];
              csvop_pkg::PH_REF: begin
                if (typ_q == csvop_pkg::ChS && acc_q != '0) err_d = 1'b1;
                ref_d = acc_q;
              end
              csvop_pkg::PH_NEWREF: begin
                if (typ_q != csvop_pkg::ChU && acc_q != '0) err_d = 1'b1;
                nref_d = acc_q;
              end
              csvop_pkg::PH_SHARES: begin
                if ((typ_q == csvop_pkg::ChS || typ_q == csvop_pkg::ChD) &&
                    acc_q != '0) err_d = 1'b1;
                shr_d = acc_q[31:0];
              end
              default: begin
                if (t_sdx && acc_q != '0) err_d = 1'b1;
                prc_d = acc_q[31:0];
              end
            endcase
            acc_d = '0;
            ph_d  = csvop_pkg::phase_e'(ph_q + 4'd1);
          end else if (is_digit) begin
            if (acc_ok) acc_d = prod[63:0]; else err_d = 1'b1;
          end else err_d = 1'b1;
        end
        csvop_pkg::PH_SIDE: begin
          if (is_comma) begin
            if (t_af || typ_q == csvop_pkg::ChS) err_d = 1'b1;
            ph_d = csvop_pkg::PH_SHARES;
          end else begin
            if (!side_ok) err_d = 1'b1;
            side_d = c;
            ph_d = csvop_pkg::PH_SIDECOMMA;
          end
        end
        csvop_pkg::PH_SIDECOMMA: begin
          if (is_comma) ph_d = csvop_pkg::PH_SHARES; else err_d = 1'b1;
        end
        csvop_pkg::PH_SYMBOL: begin
          if (t_af) begin
            if (pos_q < 4'd8) begin
              if (is_comma) err_d = 1'b1;
              else begin
                sym_d = {sym_q[55:0], c}; pos_d = pos_q + 4'd1;
              end
            end else if (is_comma) begin
              pos_d = '0; ph_d = csvop_pkg::PH_ATTR;
            end else err_d = 1'b1;
          end else if (is_comma) ph_d = csvop_pkg::PH_ATTR;
        end
        csvop_pkg::PH_ATTR: begin
          if (typ_q == csvop_pkg::ChF) begin
            if (pos_q < 4'd4) begin
              if (is_comma) err_d = 1'b1;
              else begin
                attr_d = {attr_q[23:0], c}; pos_d = pos_q + 4'd1;
              end
            end else if (is_comma) ph_d = csvop_pkg::PH_TRAIL;
            else err_d = 1'b1;
          end else if (is_comma) ph_d = csvop_pkg::PH_TRAIL;
        end
        default: if (!is_comma) err_d = 1'b1;
      endcase
    end
  end

  always_comb begin
    res = '0;
    res.ok = !err_d && ((ph_d == csvop_pkg::PH_TRAIL) ||
             ((ph_d == csvop_pkg::PH_ATTR) &&
              (typ_d != csvop_pkg::ChF || pos_d == 4'd4)));
    if (res.ok) begin
      res.msg_type = typ_d; res.stock_locate = loc_d; res.track_number = trk_d;
      res.time_stamp = stp_d; res.order_ref = ref_d; res.new_order_ref = nref_d;
      res.side_or_event = side_d; res.share_count = shr_d;
      res.price_value = prc_d; res.symbol_chars = sym_d;
      res.attribution_chars = attr_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= csvop_pkg::PH_TYPE; acc_q <= '0; err_q <= 1'b0; pos_q <= '0;
      typ_q <= '0; side_q <= '0; loc_q <= '0; trk_q <= '0; stp_q <= '0;
      ref_q <= '0; nref_q <= '0; sym_q <= '0; shr_q <= '0; prc_q <= '0;
      attr_q <= '0; ovalid_q <= 1'b0;
    end else begin
      if (take && in_data_i.is_last) ovalid_q <= 1'b1;
      else if (!out_stall_i) ovalid_q <= 1'b0;
      if (take) begin
        if (in_data_i.is_last) begin
          ph_q <= csvop_pkg::PH_TYPE; acc_q <= '0; err_q <= 1'b0; pos_q <= '0;
          typ_q <= '0; side_q <= '0; loc_q <= '0; trk_q <= '0; stp_q <= '0;
          ref_q <= '0; nref_q <= '0; sym_q <= '0; shr_q <= '0; prc_q <= '0;
          attr_q <= '0;
        end else begin
          ph_q <= ph_d; acc_q <= acc_d; err_q <= err_d; pos_q <= pos_d;
          typ_q <= typ_d; side_q <= side_d; loc_q <= loc_d; trk_q <= trk_d;
          stp_q <= stp_d; ref_q <= ref_d; nref_q <= nref_d; sym_q <= sym_d;
          shr_q <= shr_d; prc_q <= prc_d; attr_q <= attr_d;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_data_i.is_last) odata_q <= res;
  end

  property p_stall_holds;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o);
  endproperty
  a_stall_holds: assert property (p_stall_holds) else $error("result lost");

  property p_last_gives_result;
    @(posedge clk_i) disable iff (!rst_ni)
      take && in_data_i.is_last |=> out_valid_o;
  endproperty
  a_last_gives_result: assert property (p_last_gives_result)
    else $error("no result after last transfer");

  property p_reject_zero;
    @(posedge clk_i) disable iff (!rst_ni)
      out_valid_o && !out_data_o.ok |-> out_data_o.msg_type == '0;
  endproperty
  a_reject_zero: assert property (p_reject_zero) else $error("rejected not zero");

endmodule
`default_nettype wire
